@@ rtl/rvid_pkg.sv @@
`timescale 1ns / 1ps
// rvid_pkg: opcodes, format and instruction codes, and the decoded result type
// for the rv32i instruction decoder. No dependencies.

package rvid_pkg;

    // major opcodes, bits 6:0
    localparam logic [6:0] OP_R      = 7'b0110011;
    localparam logic [6:0] OP_IARITH = 7'b0010011;
    localparam logic [6:0] OP_ILOAD  = 7'b0000011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_S      = 7'b0100011;
    localparam logic [6:0] OP_SB     = 7'b1100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_UJ     = 7'b1101111;

    // funct7 variants of the R format
    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;

    typedef enum logic [3:0] {
        FMT_R       = 4'd0,
        FMT_IARITH  = 4'd1,
        FMT_ILOAD   = 4'd2,
        FMT_JALR    = 4'd3,
        FMT_S       = 4'd4,
        FMT_SB      = 4'd5,
        FMT_U       = 4'd6,
        FMT_UJ      = 4'd7,
        FMT_ILLEGAL = 4'd8
    } format_t;

    typedef enum logic [4:0] {
        ID_UNKNOWN = 5'd0,
        ID_ADD     = 5'd1,
        ID_SUB     = 5'd2,
        ID_MUL     = 5'd3,
        ID_SLL     = 5'd4,
        ID_SLT     = 5'd5,
        ID_XOR     = 5'd6,
        ID_DIV     = 5'd7,
        ID_SRL     = 5'd8,
        ID_SRA     = 5'd9,
        ID_OR      = 5'd10,
        ID_REM     = 5'd11,
        ID_AND     = 5'd12,
        ID_ADDI    = 5'd13,
        ID_ANDI    = 5'd14,
        ID_ORI     = 5'd15,
        ID_LB      = 5'd16,
        ID_LH      = 5'd17,
        ID_LW      = 5'd18,
        ID_LD      = 5'd19,
        ID_JALR    = 5'd20,
        ID_SB      = 5'd21,
        ID_SH      = 5'd22,
        ID_SW      = 5'd23,
        ID_SD      = 5'd24,
        ID_BEQ     = 5'd25,
        ID_BNE     = 5'd26,
        ID_BLT     = 5'd27,
        ID_BGE     = 5'd28,
        ID_LUI     = 5'd29,
        ID_AUIPC   = 5'd30,
        ID_JAL     = 5'd31
    } instr_id_t;

    // one decoded instruction
    typedef struct packed {
        logic [3:0]         format_class;
        logic [4:0]         instr_id;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg_one;
        logic [4:0]         src_reg_two;
        logic [2:0]         func_three;
        logic [6:0]         func_seven;
        logic signed [31:0] immediate;
        logic               uses_rs2;
        logic               writes_rd;
        logic               illegal_opcode;
    } dec_result_t;

endpackage

@@ rtl/rvid_if.sv @@
`timescale 1ns / 1ps
// rvid_instr_if and rvid_result_if: valid/ready channels for instruction words
// and decoded results. Depends on rvid_pkg.

interface rvid_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvid_result_if import rvid_pkg::*;;
    logic        valid;
    logic        ready;
    dec_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/riscv_instruction_decoder_core.sv @@
`timescale 1ns / 1ps
// riscv_instruction_decoder_core: two-stage rv32i instruction decoder.
// Depends on rvid_pkg and the channel interfaces in rvid_if.sv.
//
// channel   direction  payload                           transfer when
// instr     in         instruction_word [31:0]           instr.valid & instr.ready
// decoded   out        dec_result_t (eleven fields)      decoded.valid & decoded.ready
//
// an instr transfer reaches decoded.valid through the input register, then the
// opcode/funct decode and immediate build into the result register. one word is
// taken per cycle while the output is not stalled.
// a stall on decoded backs up through both stages; each stage refills as it drains.
// rst_n clears only the two stage valid flags.

module riscv_instruction_decoder_core
    import rvid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    rvid_instr_if.sink           instr,
    rvid_result_if.source        decoded
);

    logic        in_valid_reg;
    logic [31:0] word_reg;
    logic        out_valid_reg;
    dec_result_t result_reg;
    dec_result_t result_next;

    logic        out_ready;
    logic        in_ready;

    // stage handshakes
    assign out_ready   = !out_valid_reg || decoded.ready;
    assign in_ready    = !in_valid_reg || out_ready;
    assign instr.ready = in_ready;

    assign decoded.valid = out_valid_reg;
    assign decoded.data  = result_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= instr.valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && instr.valid)
        begin
            word_reg <= instr.instruction_word;
        end
        if (out_ready && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // field split and immediate candidates
    logic [6:0]  opcode;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_sb;
    logic [31:0] imm_u;
    logic [31:0] imm_uj;

    assign opcode = word_reg[6:0];
    assign f3     = word_reg[14:12];
    assign f7     = word_reg[31:25];
    assign imm_i  = {{20{word_reg[31]}}, word_reg[31:20]};
    assign imm_s  = {{20{word_reg[31]}}, word_reg[31:25], word_reg[11:7]};
    assign imm_sb = {{19{word_reg[31]}}, word_reg[31], word_reg[7], word_reg[30:25],
                     word_reg[11:8], 1'b0};
    assign imm_u  = {word_reg[31:12], 12'b0};
    assign imm_uj = {{11{word_reg[31]}}, word_reg[31], word_reg[19:12], word_reg[20],
                     word_reg[30:21], 1'b0};

    // R format instruction name from funct7/funct3
    instr_id_t r_id;

    always_comb
    begin
        r_id = ID_UNKNOWN;
        case (f7)
            F7_BASE:
            begin
                case (f3)
                    3'd0:    r_id = ID_ADD;
                    3'd1:    r_id = ID_SLL;
                    3'd2:    r_id = ID_SLT;
                    3'd4:    r_id = ID_XOR;
                    3'd5:    r_id = ID_SRL;
                    3'd6:    r_id = ID_OR;
                    3'd7:    r_id = ID_AND;
                    default: r_id = ID_UNKNOWN;
                endcase
            end
            F7_ALT:
            begin
                case (f3)
                    3'd0:    r_id = ID_SUB;
                    3'd5:    r_id = ID_SRA;
                    default: r_id = ID_UNKNOWN;
                endcase
            end
            F7_MULDIV:
            begin
                case (f3)
                    3'd0:    r_id = ID_MUL;
                    3'd4:    r_id = ID_DIV;
                    3'd6:    r_id = ID_REM;
                    default: r_id = ID_UNKNOWN;
                endcase
            end
            default: r_id = ID_UNKNOWN;
        endcase
    end

    // format, name, immediate and register-use flags
    format_t     fmt;
    instr_id_t   id;
    logic [31:0] imm;
    logic        use2;
    logic        wrd;
    logic        ill;

    always_comb
    begin
        fmt  = FMT_ILLEGAL;
        id   = ID_UNKNOWN;
        imm  = '0;
        use2 = 1'b0;
        wrd  = 1'b0;
        ill  = 1'b0;
        case (opcode)
            OP_R:
            begin
                fmt  = FMT_R;
                id   = r_id;
                use2 = 1'b1;
                wrd  = 1'b1;
            end
            OP_IARITH:
            begin
                fmt = FMT_IARITH;
                imm = imm_i;
                wrd = 1'b1;
                case (f3)
                    3'd0:    id = ID_ADDI;
                    3'd7:    id = ID_ANDI;
                    3'd6:    id = ID_ORI;
                    default: id = ID_UNKNOWN;
                endcase
            end
            OP_ILOAD:
            begin
                fmt = FMT_ILOAD;
                imm = imm_i;
                wrd = 1'b1;
                if (f3 inside {[3'd0:3'd3]})
                begin
                    id = instr_id_t'(ID_LB + {2'b00, f3});
                end
            end
            OP_JALR:
            begin
                fmt = FMT_JALR;
                imm = imm_i;
                wrd = 1'b1;
                if (f3 == 3'd0)
                begin
                    id = ID_JALR;
                end
            end
            OP_S:
            begin
                fmt  = FMT_S;
                imm  = imm_s;
                use2 = 1'b1;
                if (f3 inside {[3'd0:3'd3]})
                begin
                    id = instr_id_t'(ID_SB + {2'b00, f3});
                end
            end
            OP_SB:
            begin
                fmt  = FMT_SB;
                imm  = imm_sb;
                use2 = 1'b1;
                case (f3)
                    3'd0:    id = ID_BEQ;
                    3'd1:    id = ID_BNE;
                    3'd4:    id = ID_BLT;
                    3'd5:    id = ID_BGE;
                    default: id = ID_UNKNOWN;
                endcase
            end
            OP_LUI:
            begin
                fmt = FMT_U;
                imm = imm_u;
                wrd = 1'b1;
                id  = ID_LUI;
            end
            OP_AUIPC:
            begin
                fmt = FMT_U;
                imm = imm_u;
                wrd = 1'b1;
                id  = ID_AUIPC;
            end
            OP_UJ:
            begin
                fmt = FMT_UJ;
                imm = imm_uj;
                wrd = 1'b1;
                id  = ID_JAL;
            end
            default:
            begin
                ill = 1'b1;
            end
        endcase
    end

    // pack the result
    always_comb
    begin
        result_next.format_class   = fmt;
        result_next.instr_id       = id;
        result_next.dest_reg       = word_reg[11:7];
        result_next.src_reg_one    = word_reg[19:15];
        result_next.src_reg_two    = word_reg[24:20];
        result_next.func_three     = f3;
        result_next.func_seven     = f7;
        result_next.immediate      = $signed(imm);
        result_next.uses_rs2       = use2;
        result_next.writes_rd      = wrd;
        result_next.illegal_opcode = ill;
    end

    // an illegal opcode carries no name, immediate or register use
    a_illegal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid && decoded.data.illegal_opcode |->
            decoded.data.format_class == FMT_ILLEGAL && decoded.data.instr_id == ID_UNKNOWN &&
            decoded.data.immediate == 0 && !decoded.data.uses_rs2 && !decoded.data.writes_rd)
        else $error("illegal opcode result not cleared");

    // R format has no immediate and both register flags set
    a_r_format: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid && decoded.data.format_class == FMT_R |->
            decoded.data.immediate == 0 && decoded.data.uses_rs2 && decoded.data.writes_rd)
        else $error("R format flags or immediate wrong");

    // a word taken in always lands in the input stage
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        instr.valid && instr.ready |=> in_valid_reg)
        else $error("accepted word lost in input stage");

    // a new result only appears after the input stage held a word
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a decoded word");

endmodule

@@ tb/tb_riscv_instruction_decoder_core.sv @@
`timescale 1ns / 1ps
// tb_riscv_instruction_decoder_core: self-checking bench for the rv32i decoder core.
// Depends on rvid_pkg, the channel interfaces in rvid_if.sv and the core itself.

module tb_riscv_instruction_decoder_core
    import rvid_pkg::*;
;

    // funct3 encodings used by the decode tables
    localparam logic [2:0] F3_ADD_SUB = 3'd0;
    localparam logic [2:0] F3_SLL     = 3'd1;
    localparam logic [2:0] F3_SLT     = 3'd2;
    localparam logic [2:0] F3_XOR     = 3'd4;
    localparam logic [2:0] F3_SRL_SRA = 3'd5;
    localparam logic [2:0] F3_OR      = 3'd6;
    localparam logic [2:0] F3_AND     = 3'd7;
    localparam logic [2:0] F3_MUL     = 3'd0;
    localparam logic [2:0] F3_DIV     = 3'd4;
    localparam logic [2:0] F3_REM     = 3'd6;
    localparam logic [2:0] F3_JALR    = 3'd0;
    localparam logic [2:0] F3_BYTE    = 3'd0;
    localparam logic [2:0] F3_DOUBLE  = 3'd3;
    localparam logic [2:0] F3_BEQ     = 3'd0;
    localparam logic [2:0] F3_BNE     = 3'd1;
    localparam logic [2:0] F3_BLT     = 3'd4;
    localparam logic [2:0] F3_BGE     = 3'd5;

    localparam int MAX_REPORTS = 10;

    logic clk;
    logic rst_n;
    logic idle_en;
    int   mismatches = 0;
    int   stall_left = 0;

    dec_result_t decoded_q[$];

    rvid_instr_if  instr_ch();
    rvid_result_if dec_ch();

    riscv_instruction_decoder_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .instr   (instr_ch),
        .decoded (dec_ch)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // decode of one instruction word
    function automatic dec_result_t decode_instr(input logic [31:0] w);
        dec_result_t r;
        logic [6:0]  op;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] imm_i;
        op    = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        r                = '0;
        r.dest_reg       = w[11:7];
        r.src_reg_one    = w[19:15];
        r.src_reg_two    = w[24:20];
        r.func_three     = f3;
        r.func_seven     = f7;
        r.format_class   = FMT_ILLEGAL;
        r.instr_id       = ID_UNKNOWN;
        case (op)
            OP_R:
            begin
                r.format_class = FMT_R;
                r.uses_rs2     = 1'b1;
                r.writes_rd    = 1'b1;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD_SUB: r.instr_id = ID_ADD;
                        F3_SLL:     r.instr_id = ID_SLL;
                        F3_SLT:     r.instr_id = ID_SLT;
                        F3_XOR:     r.instr_id = ID_XOR;
                        F3_SRL_SRA: r.instr_id = ID_SRL;
                        F3_OR:      r.instr_id = ID_OR;
                        F3_AND:     r.instr_id = ID_AND;
                        default:    r.instr_id = ID_UNKNOWN;
                    endcase
                end
                else if (f7 == F7_ALT)
                begin
                    if (f3 == F3_ADD_SUB)
                        r.instr_id = ID_SUB;
                    else if (f3 == F3_SRL_SRA)
                        r.instr_id = ID_SRA;
                end
                else if (f7 == F7_MULDIV)
                begin
                    if (f3 == F3_MUL)
                        r.instr_id = ID_MUL;
                    else if (f3 == F3_DIV)
                        r.instr_id = ID_DIV;
                    else if (f3 == F3_REM)
                        r.instr_id = ID_REM;
                end
            end
            OP_IARITH:
            begin
                r.format_class = FMT_IARITH;
                r.immediate    = imm_i;
                r.writes_rd    = 1'b1;
                if (f3 == F3_ADD_SUB)
                    r.instr_id = ID_ADDI;
                else if (f3 == F3_AND)
                    r.instr_id = ID_ANDI;
                else if (f3 == F3_OR)
                    r.instr_id = ID_ORI;
            end
            OP_ILOAD:
            begin
                r.format_class = FMT_ILOAD;
                r.immediate    = imm_i;
                r.writes_rd    = 1'b1;
                if (f3 <= F3_DOUBLE)
                    r.instr_id = ID_LB + {2'b00, f3};
            end
            OP_JALR:
            begin
                r.format_class = FMT_JALR;
                r.immediate    = imm_i;
                r.writes_rd    = 1'b1;
                if (f3 == F3_JALR)
                    r.instr_id = ID_JALR;
            end
            OP_S:
            begin
                r.format_class = FMT_S;
                r.uses_rs2     = 1'b1;
                r.immediate    = {{20{w[31]}}, w[31:25], w[11:7]};
                if (f3 <= F3_DOUBLE)
                    r.instr_id = ID_SB + {2'b00, f3};
            end
            OP_SB:
            begin
                r.format_class = FMT_SB;
                r.uses_rs2     = 1'b1;
                r.immediate    = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    F3_BEQ:  r.instr_id = ID_BEQ;
                    F3_BNE:  r.instr_id = ID_BNE;
                    F3_BLT:  r.instr_id = ID_BLT;
                    F3_BGE:  r.instr_id = ID_BGE;
                    default: r.instr_id = ID_UNKNOWN;
                endcase
            end
            OP_LUI, OP_AUIPC:
            begin
                r.format_class = FMT_U;
                r.writes_rd    = 1'b1;
                r.immediate    = {w[31:12], 12'h000};
                r.instr_id     = (op == OP_LUI) ? ID_LUI : ID_AUIPC;
            end
            OP_UJ:
            begin
                r.format_class = FMT_UJ;
                r.writes_rd    = 1'b1;
                r.immediate    = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                r.instr_id     = ID_JAL;
            end
            default:
            begin
                r.illegal_opcode = 1'b1;
            end
        endcase
        return r;
    endfunction

    // record the expected decode for every accepted word
    always @(posedge clk)
    begin
        if (rst_n && instr_ch.valid && instr_ch.ready)
            decoded_q = {decoded_q, decode_instr(instr_ch.instruction_word)};
    end

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t %s: expected %h got %h", $realtime, name, exp_v, act_v);
        end
    endtask

    // compare each decoded transfer with the oldest expectation
    always @(posedge clk)
    begin
        dec_result_t exp_r;
        dec_result_t act_r;
        if (rst_n && dec_ch.valid && dec_ch.ready)
        begin
            act_r = dec_ch.data;
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t unexpected result %h", $realtime, act_r);
            end
            else
            begin
                exp_r = decoded_q.pop_front();
                compare_field("format_class",   32'(exp_r.format_class),
                              32'(act_r.format_class));
                compare_field("instr_id",       32'(exp_r.instr_id),
                              32'(act_r.instr_id));
                compare_field("dest_reg",       32'(exp_r.dest_reg),
                              32'(act_r.dest_reg));
                compare_field("src_reg_one",    32'(exp_r.src_reg_one),
                              32'(act_r.src_reg_one));
                compare_field("src_reg_two",    32'(exp_r.src_reg_two),
                              32'(act_r.src_reg_two));
                compare_field("func_three",     32'(exp_r.func_three),
                              32'(act_r.func_three));
                compare_field("func_seven",     32'(exp_r.func_seven),
                              32'(act_r.func_seven));
                compare_field("immediate",      exp_r.immediate,      act_r.immediate);
                compare_field("uses_rs2",       32'(exp_r.uses_rs2),
                              32'(act_r.uses_rs2));
                compare_field("writes_rd",      32'(exp_r.writes_rd),
                              32'(act_r.writes_rd));
                compare_field("illegal_opcode", 32'(exp_r.illegal_opcode),
                              32'(act_r.illegal_opcode));
            end
        end
    end

    // result-side backpressure in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dec_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            dec_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            dec_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 8);
        end
        else
        begin
            dec_ch.ready <= 1'b1;
        end
    end

    // one instruction transfer, with an optional idle burst in front
    task automatic send_word(input logic [31:0] w);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        instr_ch.valid            <= 1'b1;
        instr_ch.instruction_word <= w;
        @(posedge clk);
        while (!instr_ch.ready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] enc(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    // mostly legal opcodes with random fields, some raw noise
    function automatic logic [31:0] random_word();
        logic [31:0] r;
        logic [6:0]  op;
        logic [6:0]  f7;
        r = $urandom;
        if ($urandom_range(0, 99) < 12)
            return r;
        case ($urandom_range(0, 8))
            0:       op = OP_R;
            1:       op = OP_IARITH;
            2:       op = OP_ILOAD;
            3:       op = OP_JALR;
            4:       op = OP_S;
            5:       op = OP_SB;
            6:       op = OP_LUI;
            7:       op = OP_AUIPC;
            default: op = OP_UJ;
        endcase
        f7 = r[31:25];
        if (op == OP_R)
        begin
            case ($urandom_range(0, 3))
                0:       f7 = F7_BASE;
                1:       f7 = F7_ALT;
                2:       f7 = F7_MULDIV;
                default: f7 = r[31:25];
            endcase
        end
        return {f7, r[24:7], op};
    endfunction

    // field extremes, every format, unmatched funct and illegal opcodes
    task automatic test_directed();
        send_word(enc(F7_BASE,    5'd31, 5'd0,  F3_ADD_SUB, 5'd31, OP_R));
        send_word(enc(F7_ALT,     5'd0,  5'd31, F3_ADD_SUB, 5'd0,  OP_R));
        send_word(enc(F7_MULDIV,  5'd17, 5'd9,  F3_MUL,     5'd5,  OP_R));
        send_word(enc(F7_ALT,     5'd1,  5'd2,  F3_SRL_SRA, 5'd3,  OP_R));
        send_word(enc(F7_MULDIV,  5'd30, 5'd29, F3_REM,     5'd28, OP_R));
        // funct7 alt only pairs with sub/sra, so slt there decodes to nothing
        send_word(enc(F7_ALT,     5'd31, 5'd31, F3_SLT,     5'd31, OP_R));
        send_word({12'h7FF, 5'd1,  F3_ADD_SUB, 5'd2,  OP_IARITH});
        send_word({12'h800, 5'd31, F3_OR,      5'd31, OP_IARITH});
        send_word({12'hABC, 5'd7,  F3_SLL,     5'd8,  OP_IARITH});
        send_word({12'hFFF, 5'd0,  F3_BYTE,    5'd0,  OP_ILOAD});
        send_word({12'h000, 5'd31, F3_DOUBLE,  5'd31, OP_ILOAD});
        send_word({12'h123, 5'd4,  F3_AND,     5'd9,  OP_ILOAD});
        send_word({12'h800, 5'd1,  F3_JALR,    5'd1,  OP_JALR});
        send_word({12'h7FF, 5'd3,  F3_SLT,     5'd6,  OP_JALR});
        send_word(enc(7'h7F, 5'd31, 5'd31, F3_DOUBLE, 5'h1F, OP_S));
        send_word(enc(7'h00, 5'd0,  5'd0,  F3_BYTE,   5'h00, OP_S));
        // branch offsets at both ends of the 13-bit range
        send_word(enc(7'h40, 5'd0,  5'd0,  F3_BEQ,    5'h00, OP_SB));
        send_word(enc(7'h3F, 5'd31, 5'd31, F3_BGE,    5'h1F, OP_SB));
        send_word(enc(7'h15, 5'd10, 5'd11, F3_SLT,    5'h0A, OP_SB));
        send_word({20'hFFFFF, 5'd31, OP_LUI});
        send_word({20'h00001, 5'd0,  OP_AUIPC});
        send_word({20'hFFFFF, 5'd31, OP_UJ});
        send_word({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, OP_UJ});
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
            send_word(random_word());
    endtask

    // hold the sender until everything in flight has drained
    task automatic test_drain_pause();
        test_random_mix(20);
        instr_ch.valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        test_random_mix(20);
    endtask

    // full rate with no idling on either side
    task automatic test_back_to_back(input int count);
        idle_en = 1'b0;
        test_random_mix(count);
    endtask

    // run limit
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n                     = 1'b0;
        idle_en                   = 1'b1;
        instr_ch.valid            = 1'b0;
        instr_ch.instruction_word = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(400);
        test_drain_pause();
        test_random_mix(160);
        test_back_to_back(120);

        instr_ch.valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (mismatches == 0 && decoded_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rvid_pkg.sv
rtl/rvid_if.sv
rtl/riscv_instruction_decoder_core.sv
tb/tb_riscv_instruction_decoder_core.sv
